/* rtl/core/fqrr_pkg.sv */
// Package with the item types, codes and controller types of the four-queue drain block.
`timescale 1ns / 1ps
package fqrr_pkg;

    localparam int unsigned NUM_LANES = 4;
    localparam int unsigned TAG_BITS  = 16;

    localparam logic REQ_PUSH  = 1'b0;
    localparam logic REQ_DRAIN = 1'b1;

    localparam logic [1:0] STATUS_DRAINED  = 2'd0;
    localparam logic [1:0] STATUS_ACCEPTED = 2'd1;
    localparam logic [1:0] STATUS_DROPPED  = 2'd2;
    localparam logic [1:0] STATUS_EMPTY    = 2'd3;

    localparam logic [1:0] LANE_WEST  = 2'd0;
    localparam logic [1:0] LANE_SOUTH = 2'd1;
    localparam logic [1:0] LANE_NORTH = 2'd2;
    localparam logic [1:0] LANE_EAST  = 2'd3;

    typedef struct packed {
        logic                req_type;
        logic [1:0]          lane;
        logic [TAG_BITS-1:0] tag;
    } t_in_item;

    typedef struct packed {
        logic [1:0]          status;
        logic [TAG_BITS-1:0] out_tag;
        logic [1:0]          out_lane;
        logic                last;
    } t_out_item;

    typedef enum logic {
        ST_IDLE,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic push;
        logic drain_init;
        logic pop;
        logic empty;
    } t_cmd;

    typedef struct packed {
        logic any_ready;
        logic final_pop;
    } t_stat;

    // Lanes are served in the order west, north, south, east.
    function automatic logic [1:0] serve_lane(input logic [1:0] idx);
        logic [1:0] l;
        unique case (idx)
            2'd0:    l = LANE_WEST;
            2'd1:    l = LANE_NORTH;
            2'd2:    l = LANE_SOUTH;
            default: l = LANE_EAST;
        endcase
        return l;
    endfunction

endpackage

/* rtl/core/fqrr_ctrl.sv */
// Controller state machine that sequences pushes and drains.
`timescale 1ns / 1ps
module fqrr_ctrl
    import fqrr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  logic     i_req_type,
    input  t_stat    i_stat,
    output t_cmd     o_cmd,
    output logic     o_busy
);

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign accept = i_start && (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && (i_req_type == REQ_DRAIN)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!i_stat.any_ready || i_stat.final_pop) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.push       = accept && (i_req_type == REQ_PUSH);
                o_cmd.drain_init = accept && (i_req_type == REQ_DRAIN);
            end
            ST_DRAIN: begin
                o_busy      = 1'b1;
                o_cmd.pop   = i_stat.any_ready;
                o_cmd.empty = !i_stat.any_ready;
            end
            default: o_busy = 1'b0;
        endcase
    end

endmodule

/* rtl/core/fqrr_datapath.sv */
// Datapath with the tag memory, queue pointers, lane selection and result register.
`timescale 1ns / 1ps
module fqrr_datapath
    import fqrr_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 16,
    parameter int unsigned TAG_WIDTH   = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    input  t_in_item  i_item,
    output t_stat     o_stat,
    output logic      o_strobe,
    output t_out_item o_result
);

    localparam int unsigned SW  = (TAG_WIDTH < TAG_BITS) ? TAG_WIDTH : TAG_BITS;
    localparam int unsigned CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned HW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned MD  = NUM_LANES * QUEUE_DEPTH;
    localparam int unsigned AW  = (MD > 1) ? $clog2(MD) : 1;
    localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);
    localparam logic [CW:0]   DEPTH_X  = (CW + 1)'(QUEUE_DEPTH);

    logic [SW-1:0] mem [MD];
    logic [HW-1:0] r_head  [NUM_LANES];
    logic [CW-1:0] r_count [NUM_LANES];
    logic [1:0]    r_ord;
    logic [SW-1:0] r_rd_data;
    logic          r_sel_mem;
    logic          r_strobe;
    logic [1:0]    r_status;
    logic [1:0]    r_lane;
    logic          r_last;

    logic [NUM_LANES-1:0] nonempty;
    logic [1:0]           sel_lane;
    logic [1:0]           sel_idx;
    logic                 found;
    logic                 full;
    logic [CW:0]          tail_sum;
    logic [HW-1:0]        tail_pos;
    logic [HW-1:0]        head_next;
    logic [AW-1:0]        wr_addr;
    logic [AW-1:0]        rd_addr;
    logic                 others;

    always_comb begin
        logic [1:0] idx;
        for (int i = 0; i < NUM_LANES; i++) begin
            nonempty[i] = (r_count[i] != '0);
        end
        found    = 1'b0;
        sel_lane = LANE_WEST;
        sel_idx  = 2'd0;
        for (int k = 0; k < NUM_LANES; k++) begin
            idx = r_ord + 2'(k);
            if (!found && nonempty[serve_lane(idx)]) begin
                found    = 1'b1;
                sel_lane = serve_lane(idx);
                sel_idx  = idx;
            end
        end
        others = 1'b0;
        for (int i = 0; i < NUM_LANES; i++) begin
            if (2'(i) != sel_lane) begin
                others = others | nonempty[i];
            end
        end
    end

    assign o_stat.any_ready = found;
    assign o_stat.final_pop = found && !others && (r_count[sel_lane] == CW'(1));

    assign full     = (r_count[i_item.lane] == FULL_CNT);
    assign tail_sum = (CW + 1)'(r_head[i_item.lane]) + (CW + 1)'(r_count[i_item.lane]);
    assign tail_pos = (tail_sum >= DEPTH_X) ? HW'(tail_sum - DEPTH_X) : HW'(tail_sum);
    assign head_next = ((HW + 1)'(r_head[sel_lane]) + (HW + 1)'(1) == (HW + 1)'(QUEUE_DEPTH))
                       ? '0 : HW'((HW + 1)'(r_head[sel_lane]) + (HW + 1)'(1));
    assign wr_addr  = AW'(int'(i_item.lane) * QUEUE_DEPTH + int'(tail_pos));
    assign rd_addr  = AW'(int'(sel_lane) * QUEUE_DEPTH + int'(r_head[sel_lane]));

    always_ff @(posedge i_clk) begin
        if (i_cmd.push && !full) begin
            mem[wr_addr] <= i_item.tag[SW-1:0];
        end
        r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_LANES; i++) begin
                r_head[i]  <= '0;
                r_count[i] <= '0;
            end
            r_ord    <= 2'd0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.push || i_cmd.pop || i_cmd.empty;
            if (i_cmd.push && !full) begin
                r_count[i_item.lane] <= r_count[i_item.lane] + CW'(1);
            end
            if (i_cmd.drain_init) begin
                r_ord <= 2'd0;
            end else if (i_cmd.pop) begin
                r_ord             <= sel_idx + 2'd1;
                r_head[sel_lane]  <= head_next;
                r_count[sel_lane] <= r_count[sel_lane] - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sel_mem <= i_cmd.pop;
        if (i_cmd.pop) begin
            r_status <= STATUS_DRAINED;
            r_lane   <= sel_lane;
            r_last   <= o_stat.final_pop;
        end else if (i_cmd.empty) begin
            r_status <= STATUS_EMPTY;
            r_lane   <= LANE_WEST;
            r_last   <= 1'b1;
        end else begin
            r_status <= full ? STATUS_DROPPED : STATUS_ACCEPTED;
            r_lane   <= i_item.lane;
            r_last   <= 1'b1;
        end
    end

    assign o_strobe          = r_strobe;
    assign o_result.status   = r_status;
    assign o_result.out_tag  = r_sel_mem ? TAG_BITS'(r_rd_data) : '0;
    assign o_result.out_lane = r_lane;
    assign o_result.last     = r_last;

endmodule

/* rtl/core/four_queue_round_robin_drain_top.sv */
// Top level of the four-queue round-robin drain block.
//
// The block holds four tag queues, one per lane (west, south, north, east).
// An item is taken at a clock edge with start high and busy low. A push item
// appends its tag to the queue of its lane and gives one result in the next
// cycle, with status accepted or dropped when the queue is full. Pushes can
// be issued every cycle, since busy stays low for them.
// A drain item raises busy on the next cycle and then pops one tag per cycle,
// serving lanes in rounds in the order west, north, south, east. Each tag
// appears as a result on the cycle after its pop, so a drain keeps busy high
// while it pops and gives its results back to back; the final one carries last.
// A drain of empty queues gives one empty-status result.
// The rate is set by the single read port of the tag memory, one tag a cycle.
// Each result is shown for one cycle with o_strobe high; the receiver cannot
// stall. A synchronous reset empties every queue; the tag memory is not cleared.
`timescale 1ns / 1ps
module four_queue_round_robin_drain_top
    import fqrr_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 16,
    parameter int unsigned TAG_WIDTH   = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_in_item  i_item,
    output logic      busy,
    output logic      o_strobe,
    output t_out_item o_result
);

    t_cmd  cmd;
    t_stat stat;

    fqrr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req_type (i_item.req_type),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_busy     (busy)
    );

    fqrr_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TAG_WIDTH   (TAG_WIDTH)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_item   (i_item),
        .o_stat   (stat),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    a_push_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_item.req_type == REQ_PUSH)) |=>
        (o_strobe && o_result.last &&
         ((o_result.status == STATUS_ACCEPTED) || (o_result.status == STATUS_DROPPED))))
        else $error("push item did not give its result on the next cycle");

    a_drain_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> (o_strobe && o_result.last))
        else $error("drain ended without a final result");

    a_drained_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_result.status == STATUS_DRAINED)) |-> $past(busy))
        else $error("drained tag appeared outside a drain");

    a_busy_no_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !cmd.push)
        else $error("push taken while a drain is running");

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for the four-queue drain block with a queue predictor.
`timescale 1ns / 1ps
module tb_top;
    import fqrr_pkg::*;

    localparam int unsigned QDEPTH      = 16;
    localparam int          CYCLE_LIMIT = 400000;
    localparam logic [3:0][1:0] SERVE_SEQ = {LANE_EAST, LANE_SOUTH, LANE_NORTH, LANE_WEST};

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    t_in_item  i_item;
    logic      busy;
    logic      o_strobe;
    t_out_item o_result;

    logic [TAG_BITS-1:0] tag_mem [0:NUM_LANES-1][0:QDEPTH-1];
    logic [3:0]          q_head  [0:NUM_LANES-1];
    logic [4:0]          q_count [0:NUM_LANES-1];
    t_out_item           results_due [$];
    t_out_item           due_result;
    int                  mismatch_count = 0;
    int                  cycle_count = 0;
    int                  idle_pct = 0;

    four_queue_round_robin_drain_top #(
        .QUEUE_DEPTH(QDEPTH),
        .TAG_WIDTH  (TAG_BITS)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_item  (i_item),
        .busy    (busy),
        .o_strobe(o_strobe),
        .o_result(o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL four_queue_round_robin_drain_top");
            $finish;
        end
    end

    function automatic t_in_item make_req(input logic req, input logic [1:0] lane,
                                          input logic [TAG_BITS-1:0] tag);
        t_in_item it;
        it.req_type = req;
        it.lane     = lane;
        it.tag      = tag;
        return it;
    endfunction

    function automatic logic [TAG_BITS-1:0] rand_tag();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return '0;
        if (pick == 1) return '1;
        return TAG_BITS'($urandom_range(0, 65535));
    endfunction

    // Updates the queue state for one accepted item and appends the results it causes.
    function automatic void predict_request(input t_in_item it);
        t_out_item   res;
        t_out_item   held;
        logic        have_held;
        logic        any;
        logic [1:0]  l;
        logic [3:0]  pos;
        int          i;
        res       = '0;
        held      = '0;
        have_held = 1'b0;
        if (it.req_type == REQ_PUSH) begin
            l            = it.lane;
            res.out_lane = l;
            res.last     = 1'b1;
            if (q_count[l] >= QDEPTH) begin
                res.status = STATUS_DROPPED;
            end else begin
                pos           = 4'((q_head[l] + q_count[l]) % QDEPTH);
                tag_mem[l][pos] = it.tag;
                q_count[l]    = q_count[l] + 5'd1;
                res.status    = STATUS_ACCEPTED;
            end
            results_due.push_back(res);
        end else begin
            any = 1'b1;
            while (any) begin
                any = 1'b0;
                for (i = 0; i < NUM_LANES; i++) begin
                    l = SERVE_SEQ[i];
                    if (q_count[l] != 0) begin
                        if (have_held) results_due.push_back(held);
                        held.status   = STATUS_DRAINED;
                        held.out_tag  = tag_mem[l][q_head[l]];
                        held.out_lane = l;
                        held.last     = 1'b0;
                        have_held     = 1'b1;
                        q_head[l]     = 4'((q_head[l] + 1) % QDEPTH);
                        q_count[l]    = q_count[l] - 5'd1;
                        any           = 1'b1;
                    end
                end
            end
            if (have_held) begin
                held.last = 1'b1;
                results_due.push_back(held);
            end else begin
                res.status = STATUS_EMPTY;
                res.last   = 1'b1;
                results_due.push_back(res);
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (results_due.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual %h", $time, o_result);
                mismatch_count++;
            end else begin
                due_result = results_due.pop_front();
                if (o_result.status !== due_result.status
                        || o_result.out_tag !== due_result.out_tag
                        || o_result.out_lane !== due_result.out_lane
                        || o_result.last !== due_result.last) begin
                    $display("%0t: mismatch: expected %h, actual %h",
                             $time, due_result, o_result);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic send_item(input t_in_item it);
        @(negedge i_clk);
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_request(it);
    endtask

    task automatic idle_for(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            start  <= 1'b0;
            i_item <= make_req(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), rand_tag());
        end
    endtask

    task automatic wait_results_done();
        do begin
            @(negedge i_clk);
            start <= 1'b0;
        end while (results_due.size() != 0);
    endtask

    task automatic maybe_idle();
        while ($urandom_range(0, 99) < idle_pct) idle_for(1);
    endtask

    task automatic test_empty_drain();
        send_item(make_req(REQ_DRAIN, 2'($urandom_range(0, 3)), rand_tag()));
    endtask

    task automatic test_serve_order();
        send_item(make_req(REQ_PUSH, LANE_WEST, 16'h0000));
        send_item(make_req(REQ_PUSH, LANE_WEST, 16'h0001));
        send_item(make_req(REQ_PUSH, LANE_SOUTH, 16'hFFFF));
        send_item(make_req(REQ_PUSH, LANE_EAST, 16'h8000));
        send_item(make_req(REQ_PUSH, LANE_NORTH, 16'h7FFF));
        send_item(make_req(REQ_DRAIN, LANE_EAST, 16'hFFFF));
    endtask

    task automatic test_full_lane();
        repeat (QDEPTH + 1) send_item(make_req(REQ_PUSH, LANE_EAST, rand_tag()));
        send_item(make_req(REQ_DRAIN, LANE_WEST, 16'h0000));
    endtask

    // The sender holds off with pushes queued and a drain in flight until the drain completes.
    task automatic test_drain_pause();
        repeat (8) send_item(make_req(REQ_PUSH, 2'($urandom_range(0, 3)), rand_tag()));
        send_item(make_req(REQ_DRAIN, 2'($urandom_range(0, 3)), rand_tag()));
        wait_results_done();
    endtask

    // Mostly pushes with occasional drains; bursts of 12 to 20 pushes into one lane can fill it and wrap its pointers.
    task automatic test_random_traffic(input int pct, input int count);
        int          sent;
        int          pick;
        int          burst;
        logic [1:0]  lane;
        idle_pct = pct;
        sent     = 0;
        while (sent < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 7) begin
                maybe_idle();
                send_item(make_req(REQ_DRAIN, 2'($urandom_range(0, 3)), rand_tag()));
                sent++;
            end else if (pick < 12) begin
                lane  = 2'($urandom_range(0, 3));
                burst = $urandom_range(12, 20);
                repeat (burst) begin
                    maybe_idle();
                    send_item(make_req(REQ_PUSH, lane, rand_tag()));
                end
                sent += burst;
            end else begin
                maybe_idle();
                send_item(make_req(REQ_PUSH, 2'($urandom_range(0, 3)), rand_tag()));
                sent++;
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_item  = '0;
        for (int l = 0; l < NUM_LANES; l++) begin
            q_head[l]  = '0;
            q_count[l] = '0;
        end
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_drain();
        test_serve_order();
        test_full_lane();
        test_random_traffic(0, 90);
        test_drain_pause();
        test_random_traffic(54, 86);
        test_random_traffic(16, 86);

        wait_results_done();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("PASS four_queue_round_robin_drain_top");
        end else begin
            $display("FAIL four_queue_round_robin_drain_top");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/core/fqrr_pkg.sv
rtl/core/fqrr_ctrl.sv
rtl/core/fqrr_datapath.sv
rtl/core/four_queue_round_robin_drain_top.sv
sim/tb_top.sv
